@@ rtl/ids_pkg.sv @@
// Package for the include directive scanner: scan modes, result kinds,
// character constants and the keyword lookup.
// No dependencies.
package ids_pkg;

  typedef enum logic [2:0] {
    MODE_PLAIN = 3'd0,
    MODE_BLOCK = 3'd1,
    MODE_LINE  = 3'd2,
    MODE_AFTER = 3'd3,
    MODE_ANGLE = 3'd4,
    MODE_QUOTE = 3'd5
  } scan_mode_e;

  typedef enum logic [1:0] {
    KIND_CHAR    = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_ABANDON = 2'd2
  } item_kind_e;

  localparam logic [7:0] ChrNul    = 8'h00;
  localparam logic [7:0] ChrTab    = 8'h09;
  localparam logic [7:0] ChrNl     = 8'h0A;
  localparam logic [7:0] ChrSpace  = 8'h20;
  localparam logic [7:0] ChrQuote  = 8'h22;
  localparam logic [7:0] ChrHash   = 8'h23;
  localparam logic [7:0] ChrStar   = 8'h2A;
  localparam logic [7:0] ChrSlash  = 8'h2F;
  localparam logic [7:0] ChrLt     = 8'h3C;
  localparam logic [7:0] ChrGt     = 8'h3E;

  localparam logic [2:0] KwLast = 3'd7;

  // Characters of "#include" by position.
  function automatic logic [7:0] kw_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = ChrHash;
      3'd1:    ch = 8'h69;  // i
      3'd2:    ch = 8'h6E;  // n
      3'd3:    ch = 8'h63;  // c
      3'd4:    ch = 8'h6C;  // l
      3'd5:    ch = 8'h75;  // u
      3'd6:    ch = 8'h64;  // d
      default: ch = 8'h65;  // e
    endcase
    return ch;
  endfunction

endpackage

@@ rtl/ids_byte_if.sv @@
// Input channel of the include directive scanner: one text byte per word.
// Depends on nothing.
interface ids_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

@@ rtl/ids_name_if.sv @@
// Result channel of the include directive scanner: name characters and markers.
// Depends on nothing.
interface ids_name_if;
  logic       valid;
  logic       ready;
  logic [7:0] name_char;
  logic [1:0] item_kind;
  logic       is_system;

  modport source (output valid, output name_char, output item_kind, output is_system,
                  input ready);
  modport sink   (input valid, input name_char, input item_kind, input is_system,
                  output ready);
endinterface

@@ rtl/include_directive_scanner.sv @@
// Include directive scanner: comment skipping, "#include" match, name streaming.
// Depends on ids_pkg, ids_byte_if and ids_name_if.
//
// Usage:
//   in_i  carries one source text byte per word; a zero byte ends the text,
//         resets the scanner and, if a name is open, yields an abandon marker.
//   out_o carries one word per file name character, then a completion marker
//         (name_char zero) at the closing '>' or '"'.
// Path: a byte accepted into the input register is decoded from there; its word,
//   if any, is registered in the output register that drives out_o.
// Throughput: one byte per cycle when the output register is free or being taken.
//   The scan state is a few flops, one compare level per byte; nothing iterates.
// Stall: a waiting result sits in the output register; the decode stage still
//   takes the next byte only when the output register is free or being taken,
//   and in_i.ready drops once the input register also holds a byte.
// Reset: rst_ni clears the scan state to plain text and empties both stages.
module include_directive_scanner (
  input  logic       clk_i,
  input  logic       rst_ni,
  ids_byte_if.sink   in_i,
  ids_name_if.source out_o
);

  // Input register
  logic       byte_vld_q;
  logic [7:0] byte_q;

  // Scan state
  ids_pkg::scan_mode_e mode_q, mode_d;
  logic [2:0]          cnt_q, cnt_d;
  logic                slash_q, slash_d;
  logic                star_q, star_d;

  // Result register
  logic                out_vld_q, out_vld_d;
  logic [7:0]          out_char_q;
  ids_pkg::item_kind_e out_kind_q;
  logic                out_sys_q;

  logic                out_free, fire;
  logic                emit;
  logic [7:0]          emit_char;
  ids_pkg::item_kind_e emit_kind;
  logic                emit_sys;
  logic                run_plain, plain_fall;

  assign out_free = !out_vld_q || out_o.ready;
  assign fire     = byte_vld_q && out_free;
  assign in_i.ready = !byte_vld_q || fire;

  // Next scan state
  always_comb begin
    mode_d     = mode_q;
    cnt_d      = cnt_q;
    slash_d    = slash_q;
    star_d     = star_q;
    run_plain  = 1'b0;
    plain_fall = 1'b1;

    if (byte_q == ids_pkg::ChrNul) begin
      mode_d  = ids_pkg::MODE_PLAIN;
      cnt_d   = '0;
      slash_d = 1'b0;
      star_d  = 1'b0;
    end else begin
      unique case (mode_q)
        ids_pkg::MODE_BLOCK: begin
          if (byte_q == ids_pkg::ChrStar) begin
            star_d = 1'b1;
          end else if (byte_q == ids_pkg::ChrSlash && star_q) begin
            star_d = 1'b0;
            mode_d = ids_pkg::MODE_PLAIN;
          end else begin
            star_d = 1'b0;
          end
        end
        ids_pkg::MODE_LINE: begin
          if (byte_q == ids_pkg::ChrNl) mode_d = ids_pkg::MODE_PLAIN;
        end
        ids_pkg::MODE_AFTER: begin
          if (byte_q == ids_pkg::ChrLt) begin
            mode_d = ids_pkg::MODE_ANGLE;
          end else if (byte_q == ids_pkg::ChrQuote) begin
            mode_d = ids_pkg::MODE_QUOTE;
          end else if (byte_q != ids_pkg::ChrSpace && byte_q != ids_pkg::ChrTab &&
                       byte_q != ids_pkg::ChrNl) begin
            // re-examine this byte as plain text
            run_plain = 1'b1;
          end
        end
        ids_pkg::MODE_ANGLE: begin
          if (byte_q == ids_pkg::ChrGt) mode_d = ids_pkg::MODE_PLAIN;
        end
        ids_pkg::MODE_QUOTE: begin
          if (byte_q == ids_pkg::ChrQuote) mode_d = ids_pkg::MODE_PLAIN;
        end
        default: run_plain = 1'b1;
      endcase

      if (run_plain) begin
        mode_d = ids_pkg::MODE_PLAIN;
        if (slash_q) begin
          slash_d = 1'b0;
          if (byte_q == ids_pkg::ChrStar) begin
            mode_d     = ids_pkg::MODE_BLOCK;
            star_d     = 1'b0;
            plain_fall = 1'b0;
          end else if (byte_q == ids_pkg::ChrSlash) begin
            mode_d     = ids_pkg::MODE_LINE;
            plain_fall = 1'b0;
          end
        end else if (cnt_q != '0) begin
          if (byte_q == ids_pkg::kw_char(cnt_q)) begin
            plain_fall = 1'b0;
            if (cnt_q == ids_pkg::KwLast) begin
              cnt_d  = '0;
              mode_d = ids_pkg::MODE_AFTER;
            end else begin
              cnt_d = cnt_q + 3'd1;
            end
          end else begin
            cnt_d = '0;
          end
        end
        if (plain_fall) begin
          if (byte_q == ids_pkg::ChrSlash) begin
            slash_d = 1'b1;
          end else if (byte_q == ids_pkg::ChrHash) begin
            cnt_d = 3'd1;
          end
        end
      end
    end
  end

  // Result word for the byte in the input register
  always_comb begin
    emit      = 1'b0;
    emit_char = ids_pkg::ChrNul;
    emit_kind = ids_pkg::KIND_CHAR;
    emit_sys  = 1'b0;

    if (byte_q == ids_pkg::ChrNul) begin
      if (mode_q == ids_pkg::MODE_ANGLE || mode_q == ids_pkg::MODE_QUOTE) begin
        emit      = 1'b1;
        emit_kind = ids_pkg::KIND_ABANDON;
        emit_sys  = (mode_q == ids_pkg::MODE_ANGLE);
      end
    end else begin
      unique case (mode_q)
        ids_pkg::MODE_ANGLE: begin
          emit     = 1'b1;
          emit_sys = 1'b1;
          if (byte_q == ids_pkg::ChrGt) begin
            emit_kind = ids_pkg::KIND_DONE;
          end else begin
            emit_char = byte_q;
          end
        end
        ids_pkg::MODE_QUOTE: begin
          emit = 1'b1;
          if (byte_q == ids_pkg::ChrQuote) begin
            emit_kind = ids_pkg::KIND_DONE;
          end else begin
            emit_char = byte_q;
          end
        end
        default: emit = 1'b0;
      endcase
    end
  end

  assign out_vld_d = fire ? emit : (out_vld_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
      mode_q     <= ids_pkg::MODE_PLAIN;
      cnt_q      <= '0;
      slash_q    <= 1'b0;
      star_q     <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (in_i.ready) byte_vld_q <= in_i.valid;
      if (fire) begin
        mode_q  <= mode_d;
        cnt_q   <= cnt_d;
        slash_q <= slash_d;
        star_q  <= star_d;
      end
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) byte_q <= in_i.text_byte;
    if (fire && emit) begin
      out_char_q <= emit_char;
      out_kind_q <= emit_kind;
      out_sys_q  <= emit_sys;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.name_char = out_char_q;
  assign out_o.item_kind = out_kind_q;
  assign out_o.is_system = out_sys_q;

endmodule

@@ rtl/ids_checker.sv @@
// Port-level checks for the include directive scanner, bound to the top level.
// Depends on ids_pkg and include_directive_scanner.
module ids_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic [7:0] text_byte_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] name_char_i,
  input logic [1:0] item_kind_i,
  input logic       is_system_i
);

  // Hold a stalled result word.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(name_char_i) &&
      $stable(item_kind_i) && $stable(is_system_i))
    else $error("result word changed while stalled");

  // Markers carry no character.
  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && item_kind_i != ids_pkg::KIND_CHAR |-> name_char_i == ids_pkg::ChrNul)
    else $error("marker word with nonzero character");

  // A fresh result comes from an accepted source byte.
  a_rise_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result word without a source byte");

  // An abandon marker follows an end-of-text byte; a completion a closer.
  a_rise_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) && item_kind_i != ids_pkg::KIND_CHAR |->
      (item_kind_i == ids_pkg::KIND_ABANDON && $past(text_byte_i, 2) == ids_pkg::ChrNul) ||
      (item_kind_i == ids_pkg::KIND_DONE && is_system_i &&
        $past(text_byte_i, 2) == ids_pkg::ChrGt) ||
      (item_kind_i == ids_pkg::KIND_DONE && !is_system_i &&
        $past(text_byte_i, 2) == ids_pkg::ChrQuote))
    else $error("marker word does not match its source byte");

endmodule

bind include_directive_scanner ids_checker u_ids_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .text_byte_i (in_i.text_byte),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .name_char_i (out_o.name_char),
  .item_kind_i (out_o.item_kind),
  .is_system_i (out_o.is_system)
);

@@ sim/tb_include_directive_scanner.sv @@
// Testbench for include_directive_scanner: drives source text bytes and checks the
// streamed file name words against a byte-level scan predictor.
// Depends on ids_pkg, ids_byte_if, ids_name_if and the scanner RTL.
module tb_include_directive_scanner;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 200;
  localparam int RandBytes  = 780;
  localparam int QuietBytes = 150;
  localparam int TailCycles = 8;

  typedef struct packed {
    logic [7:0]          ch;
    ids_pkg::item_kind_e kind;
    logic                sys;
  } name_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ids_byte_if text_if ();
  ids_name_if name_if ();

  include_directive_scanner i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (text_if.sink),
    .out_o  (name_if.source)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predicted scanner state.
  ids_pkg::scan_mode_e mode_q  = ids_pkg::MODE_PLAIN;
  logic [2:0]          match_q = 3'd0;
  logic                slash_q = 1'b0;
  logic                star_q  = 1'b0;

  name_word_t name_q[$];
  int         mismatch_cnt = 0;
  int         cycle_cnt    = 0;
  int         bytes_sent   = 0;
  bit         idle_ok      = 1'b1;
  bit         quiet        = 1'b0;
  bit         hold_req     = 1'b0;

  localparam logic [7:0] IncludeWord [8] = '{
    ids_pkg::ChrHash, 8'h69, 8'h6E, 8'h63, 8'h6C, 8'h75, 8'h64, 8'h65
  };

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  // Plain text: comment openers and the keyword match.
  function automatic void plain_text_byte(input logic [7:0] c);
    if (slash_q) begin
      slash_q = 1'b0;
      if (c == ids_pkg::ChrStar) begin
        mode_q = ids_pkg::MODE_BLOCK;
        star_q = 1'b0;
        return;
      end
      if (c == ids_pkg::ChrSlash) begin
        mode_q = ids_pkg::MODE_LINE;
        return;
      end
    end else if (match_q != 3'd0) begin
      if (c == IncludeWord[match_q]) begin
        if (match_q == ids_pkg::KwLast) begin
          match_q = 3'd0;
          mode_q  = ids_pkg::MODE_AFTER;
        end else begin
          match_q = match_q + 3'd1;
        end
        return;
      end
      match_q = 3'd0;
    end
    if (c == ids_pkg::ChrSlash) slash_q = 1'b1;
    else if (c == ids_pkg::ChrHash) match_q = 3'd1;
  endfunction

  function automatic void scan_byte(input logic [7:0] c);
    if (c == ids_pkg::ChrNul) begin
      if (mode_q == ids_pkg::MODE_ANGLE || mode_q == ids_pkg::MODE_QUOTE)
        name_q.push_back('{ch: ids_pkg::ChrNul, kind: ids_pkg::KIND_ABANDON,
                           sys: (mode_q == ids_pkg::MODE_ANGLE)});
      mode_q  = ids_pkg::MODE_PLAIN;
      match_q = 3'd0;
      slash_q = 1'b0;
      star_q  = 1'b0;
      return;
    end
    case (mode_q)
      ids_pkg::MODE_BLOCK: begin
        if (c == ids_pkg::ChrStar) begin
          star_q = 1'b1;
        end else if (c == ids_pkg::ChrSlash && star_q) begin
          star_q = 1'b0;
          mode_q = ids_pkg::MODE_PLAIN;
        end else begin
          star_q = 1'b0;
        end
      end
      ids_pkg::MODE_LINE: begin
        if (c == ids_pkg::ChrNl) mode_q = ids_pkg::MODE_PLAIN;
      end
      ids_pkg::MODE_AFTER: begin
        if (c == ids_pkg::ChrLt) begin
          mode_q = ids_pkg::MODE_ANGLE;
        end else if (c == ids_pkg::ChrQuote) begin
          mode_q = ids_pkg::MODE_QUOTE;
        end else if (c != ids_pkg::ChrSpace && c != ids_pkg::ChrTab &&
                     c != ids_pkg::ChrNl) begin
          // re-examine the byte as plain text
          mode_q = ids_pkg::MODE_PLAIN;
          plain_text_byte(c);
        end
      end
      ids_pkg::MODE_ANGLE: begin
        if (c == ids_pkg::ChrGt) begin
          name_q.push_back('{ch: ids_pkg::ChrNul, kind: ids_pkg::KIND_DONE, sys: 1'b1});
          mode_q = ids_pkg::MODE_PLAIN;
        end else begin
          name_q.push_back('{ch: c, kind: ids_pkg::KIND_CHAR, sys: 1'b1});
        end
      end
      ids_pkg::MODE_QUOTE: begin
        if (c == ids_pkg::ChrQuote) begin
          name_q.push_back('{ch: ids_pkg::ChrNul, kind: ids_pkg::KIND_DONE, sys: 1'b0});
          mode_q = ids_pkg::MODE_PLAIN;
        end else begin
          name_q.push_back('{ch: c, kind: ids_pkg::KIND_CHAR, sys: 1'b0});
        end
      end
      default: begin
        mode_q = ids_pkg::MODE_PLAIN;
        plain_text_byte(c);
      end
    endcase
  endfunction

  // Offer one byte, hold it until accepted, then predict.
  task automatic send_byte(input logic [7:0] b);
    if (idle_ok && !quiet && $urandom_range(0, 4) == 0) begin
      text_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    text_if.valid     <= 1'b1;
    text_if.text_byte <= b;
    do @(posedge clk_i); while (text_if.ready !== 1'b1);
    scan_byte(b);
    bytes_sent++;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Pause the sender until every predicted word has come out.
  task automatic drain_names();
    text_if.valid <= 1'b0;
    do @(posedge clk_i); while (name_q.size() != 0);
  endtask

  function automatic logic [7:0] random_blank();
    case ($urandom_range(0, 2))
      0:       return ids_pkg::ChrSpace;
      1:       return ids_pkg::ChrTab;
      default: return ids_pkg::ChrNl;
    endcase
  endfunction

  task automatic test_end_of_text();
    send_byte(8'hFF);
    send_byte(ids_pkg::ChrNul);
  endtask

  task automatic test_angle_name();
    send_str("#include <");
    send_byte(8'hFF);
    send_byte(ids_pkg::ChrNl);
    send_byte(ids_pkg::ChrGt);
  endtask

  task automatic test_empty_quoted();
    send_str("#include\t\"\"");
  endtask

  task automatic test_abandoned_name();
    send_str("#include\n<a");
    send_byte(ids_pkg::ChrNul);
  endtask

  task automatic test_comment_openers();
    send_str("/*/#include<x>*/#include\"q\"");
    send_str("//#include<y>\n");
  endtask

  task automatic test_broken_token();
    send_str("#inc#include<z>#include x#include//c\n");
  endtask

  // Receiver holds off while a long name streams in, so the input stalls.
  task automatic test_output_hold();
    hold_req = 1'b1;
    send_str("#include <");
    repeat (40) send_byte(8'($urandom_range(32, 61)));
    send_byte(ids_pkg::ChrGt);
  endtask

  task automatic test_random_text();
    int         stop_at;
    int         len;
    int         cut;
    logic       sys;
    logic [7:0] c;
    logic [7:0] close_c;
    string      kw = "#include";
    stop_at = bytes_sent + RandBytes;
    while (bytes_sent < stop_at) begin
      idle_ok = ($urandom_range(0, 3) != 0);
      quiet   = (bytes_sent > stop_at - QuietBytes);
      case ($urandom_range(0, 9)) inside
        [0:3]: begin
          send_str(kw);
          repeat ($urandom_range(0, 3)) send_byte(random_blank());
          sys     = 1'($urandom_range(0, 1));
          close_c = sys ? ids_pkg::ChrGt : ids_pkg::ChrQuote;
          send_byte(sys ? ids_pkg::ChrLt : ids_pkg::ChrQuote);
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
          repeat (len) begin
            do begin
              c = 8'($urandom_range(0, 1) ? $urandom_range(32, 126) : $urandom_range(1, 255));
            end while (c == close_c);
            send_byte(c);
          end
          // mostly close; sometimes end the text or leave the name open
          case ($urandom_range(0, 15))
            0:       send_byte(ids_pkg::ChrNul);
            1:       ;
            default: send_byte(close_c);
          endcase
        end
        4: begin
          cut = $urandom_range(1, 8);
          for (int i = 0; i < cut; i++) send_byte(kw[i]);
          if (cut == 8) repeat ($urandom_range(0, 2)) send_byte(random_blank());
          send_byte(8'($urandom_range(1, 255)));
        end
        5: begin
          send_str("/*");
          repeat ($urandom_range(0, 10)) begin
            case ($urandom_range(0, 3))
              0:       send_byte(ids_pkg::ChrStar);
              1:       send_byte(ids_pkg::ChrSlash);
              2:       send_byte(ids_pkg::ChrHash);
              default: send_byte(8'($urandom_range(1, 255)));
            endcase
          end
          send_str("*/");
        end
        6: begin
          send_str("//");
          repeat ($urandom_range(0, 8)) send_byte(8'($urandom_range(1, 255)));
          send_byte(ids_pkg::ChrNl);
        end
        7: send_byte(ids_pkg::ChrNul);
        default: repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  // Receiver pacing: random stall bursts, one long hold-off on request.
  initial begin : sink_pacing
    name_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        name_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (quiet || $urandom_range(0, 2) != 0) begin
        name_if.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        name_if.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : name_check
    name_word_t want;
    if (rst_ni === 1'b1 && name_if.valid === 1'b1 && name_if.ready === 1'b1) begin
      if (name_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word char %02h kind %0d sys %0b",
                                  name_if.name_char, name_if.item_kind, name_if.is_system));
      end else begin
        want = name_q.pop_front();
        if (name_if.name_char !== want.ch)
          report_mismatch($sformatf("name_char %02h, predicted %02h",
                                    name_if.name_char, want.ch));
        if (name_if.item_kind !== want.kind)
          report_mismatch($sformatf("item_kind %0d, predicted %0d",
                                    name_if.item_kind, want.kind));
        if (name_if.is_system !== want.sys)
          report_mismatch($sformatf("is_system %0b, predicted %0b",
                                    name_if.is_system, want.sys));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_cnt, name_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_ni            <= 1'b0;
    text_if.valid     <= 1'b0;
    text_if.text_byte <= ids_pkg::ChrNul;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_end_of_text();
    test_angle_name();
    test_empty_quoted();
    test_abandoned_name();
    test_comment_openers();
    test_broken_token();
    drain_names();
    test_output_hold();
    drain_names();
    test_random_text();
    drain_names();
    repeat (TailCycles) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/ids_pkg.sv
rtl/ids_byte_if.sv
rtl/ids_name_if.sv
rtl/include_directive_scanner.sv
rtl/ids_checker.sv
sim/tb_include_directive_scanner.sv
